// File: rtl/core/ioreb_pkg.sv
package ioreb_pkg;

  localparam int unsigned MAX_OUT = 32;
  localparam int unsigned CNT_W   = $clog2(MAX_OUT + 1);

  typedef enum logic [1:0] {
    KIND_RELEASED = 2'd0,
    KIND_PARKED   = 2'd1,
    KIND_BEYOND   = 2'd2,
    KIND_STALE    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

// File: rtl/core/ioreb_ram.sv
module ioreb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/in_order_release_reorder_buffer.sv
// In-order release reorder buffer.
// Request channel: in_sequence and in_handle are taken at a clock edge with
// start high and busy low. A request behind the expected sequence is
// reported stale, one at or beyond expected + WINDOW is reported beyond the
// window; neither is parked. Any other request is parked in its window
// slot (handle kept in a WINDOW-deep RAM); a resend overwrites the slot.
// Then every consecutive parked request from the expected sequence on is
// released in order, at most 32 results per request; the rest go out after
// the next request.
// Results: one cycle wide on the out_ ports, marked by out_valid; the
// receiver cannot stall, so every strobe must be taken.
// Timing: a report is registered and shows in the cycle after the request.
// A release run first reads the handle RAM in the read state, then gives one
// result per cycle in the emit state; busy stays high from the read state on.
// Releases read the handle RAM once per cycle; that read port sets the rate.
// cfg_we loads the expected sequence from cfg_data and drops every parked
// entry; write only while busy is low and no result is pending.
// Reset: expected sequence 1, nothing parked, no result pending.
module in_order_release_reorder_buffer
  import ioreb_pkg::*;
#(
  parameter int unsigned WINDOW      = 32,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [63:0]            in_sequence,
  input  logic [HANDLE_BITS-1:0] in_handle,
  input  logic                   cfg_we,
  input  logic [63:0]            cfg_data,
  output logic                   out_valid,
  output logic [1:0]             out_result_kind,
  output logic [63:0]            out_sequence,
  output logic [HANDLE_BITS-1:0] out_handle,
  output logic [63:0]            out_applied_count,
  output logic                   out_last_of_run
);

  localparam int unsigned SLOT_W = $clog2(WINDOW);

  state_t                 state_r, state_nxt;
  logic [63:0]            next_r, next_nxt;
  logic [SLOT_W-1:0]      base_r, base_nxt;
  logic [WINDOW-1:0]      waiting_r, waiting_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;

  logic                   out_valid_r, out_valid_nxt;
  kind_t                  kind_r, kind_nxt;
  logic [63:0]            oseq_r, oseq_nxt;
  logic [HANDLE_BITS-1:0] ohandle_r, ohandle_nxt;
  logic [63:0]            applied_r, applied_nxt;
  logic                   last_r, last_nxt;

  logic [64:0]            diff;
  logic                   stale, beyond, accept;
  logic [SLOT_W:0]        park_sum;
  logic [SLOT_W-1:0]      park_slot, slot_inc;
  logic [CNT_W-1:0]       cnt_after;

  logic                   ram_we, ram_re;
  logic [SLOT_W-1:0]      ram_raddr;
  logic [HANDLE_BITS-1:0] ram_rdata;

  assign accept   = start && (state_r == ST_IDLE);
  assign diff     = {1'b0, in_sequence} - {1'b0, next_r};
  assign stale    = diff[64];
  assign beyond   = !stale && (diff[63:0] >= 64'(WINDOW));
  assign park_sum = {1'b0, base_r} + {1'b0, diff[SLOT_W-1:0]};
  assign park_slot = (park_sum >= (SLOT_W+1)'(WINDOW)) ?
                     SLOT_W'(park_sum - (SLOT_W+1)'(WINDOW)) : park_sum[SLOT_W-1:0];
  assign slot_inc  = (base_r == SLOT_W'(WINDOW - 1)) ? '0 : base_r + SLOT_W'(1);
  assign cnt_after = cnt_r + CNT_W'(1);

  assign ram_we    = accept && !cfg_we && !stale && !beyond;
  assign ram_re    = (state_r == ST_READ) || (state_r == ST_EMIT);
  assign ram_raddr = (state_r == ST_READ) ? base_r : slot_inc;

  ioreb_ram #(
    .WIDTH(HANDLE_BITS),
    .DEPTH(WINDOW)
  ) u_handle_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(park_slot),
    .wdata(in_handle),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    next_nxt      = next_r;
    base_nxt      = base_r;
    waiting_nxt   = waiting_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    kind_nxt      = kind_r;
    oseq_nxt      = oseq_r;
    ohandle_nxt   = ohandle_r;
    applied_nxt   = applied_r;
    last_nxt      = last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_we) begin
          next_nxt    = cfg_data;
          base_nxt    = '0;
          waiting_nxt = '0;
        end else if (start) begin
          oseq_nxt    = in_sequence;
          ohandle_nxt = in_handle;
          applied_nxt = next_r - 64'd1;
          last_nxt    = !waiting_r[base_r];
          cnt_nxt     = '0;
          if (stale || beyond) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = stale ? KIND_STALE : KIND_BEYOND;
            cnt_nxt       = CNT_W'(1);
            if (waiting_r[base_r]) begin
              state_nxt = ST_READ;
            end
          end else begin
            waiting_nxt[park_slot] = 1'b1;
            if (diff[63:0] != 64'd0) begin
              out_valid_nxt = 1'b1;
              kind_nxt      = KIND_PARKED;
              cnt_nxt       = CNT_W'(1);
              if (waiting_r[base_r]) begin
                state_nxt = ST_READ;
              end
            end else begin
              state_nxt = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_nxt       = 1'b1;
        kind_nxt            = KIND_RELEASED;
        oseq_nxt            = next_r;
        ohandle_nxt         = ram_rdata;
        applied_nxt         = next_r;
        waiting_nxt[base_r] = 1'b0;
        next_nxt            = next_r + 64'd1;
        base_nxt            = slot_inc;
        cnt_nxt             = cnt_after;
        last_nxt            = (cnt_after == CNT_W'(MAX_OUT)) || !waiting_r[slot_inc];
        if (last_nxt) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      next_r      <= 64'd1;
      base_r      <= '0;
      waiting_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_r      <= next_nxt;
      base_r      <= base_nxt;
      waiting_r   <= waiting_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    oseq_r    <= oseq_nxt;
    ohandle_r <= ohandle_nxt;
    applied_r <= applied_nxt;
    last_r    <= last_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_result_kind   = kind_r;
  assign out_sequence      = oseq_r;
  assign out_handle        = ohandle_r;
  assign out_applied_count = applied_r;
  assign out_last_of_run   = last_r;

`ifndef SYNTH
  // a release run only starts on a parked entry
  a_read_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> waiting_r[base_r])
    else $error("release run started on an empty slot");

  // every release reports its own sequence as the applied count
  a_release_applied: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == KIND_RELEASED)) |-> (out_applied_count == out_sequence))
    else $error("applied count mismatch on release");

  // a request always gives a result or keeps the block busy
  a_request_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !cfg_we) |=> (out_valid || busy))
    else $error("request produced no activity");

  // release budget per request
  a_budget: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (cnt_r < CNT_W'(MAX_OUT)))
    else $error("release budget exceeded");
`endif

endmodule

// File: tb/testbench.sv
module testbench;
  import ioreb_pkg::*;

  localparam int unsigned WINDOW       = 32;
  localparam int unsigned HANDLE_BITS  = 16;
  localparam int unsigned SLOT_W       = $clog2(WINDOW);
  localparam int          RANDOM_ITEMS = 370;
  localparam int          DRAIN_CYCLES = WINDOW + 8;
  localparam int          QUIET_LIMIT  = 1000;
  localparam logic [63:0] TOP          = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    kind_t                  kind;
    logic [63:0]            seq;
    logic [HANDLE_BITS-1:0] hdl;
    logic [63:0]            applied;
    logic                   last;
  } result_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_op_t;

  typedef struct packed {
    row_op_t                op;
    logic [63:0]            seq;
    logic [HANDLE_BITS-1:0] hdl;
    logic                   typed;
    kind_t                  kind;
    logic [63:0]            applied;
  } dir_row_t;

  localparam int DIR_ROWS = 21;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_REQ, 64'd0,      16'h0000, 1'b1, KIND_STALE,    64'd0},
    '{ROW_REQ, 64'd33,     16'hFFFF, 1'b1, KIND_BEYOND,   64'd0},
    '{ROW_REQ, 64'd32,     16'h1234, 1'b0, KIND_PARKED,   64'd0},
    '{ROW_REQ, 64'd1,      16'h0001, 1'b1, KIND_RELEASED, 64'd1},
    '{ROW_REQ, 64'd5,      16'hAAAA, 1'b0, KIND_PARKED,   64'd0},
    '{ROW_REQ, 64'd5,      16'h5555, 1'b0, KIND_PARKED,   64'd0},
    '{ROW_REQ, 64'd3,      16'h0F0F, 1'b0, KIND_PARKED,   64'd0},
    '{ROW_REQ, 64'd2,      16'hF0F0, 1'b0, KIND_RELEASED, 64'd0},
    '{ROW_REQ, 64'd4,      16'h8001, 1'b0, KIND_RELEASED, 64'd0},
    '{ROW_CFG, TOP - 64'd1, 16'h0000, 1'b0, KIND_RELEASED, 64'd0},
    '{ROW_REQ, 64'd0,      16'h7FFF, 1'b1, KIND_STALE,    TOP - 64'd2},
    '{ROW_REQ, TOP,        16'h0F0F, 1'b0, KIND_PARKED,   64'd0},
    '{ROW_REQ, TOP - 64'd1, 16'hC3C3, 1'b0, KIND_RELEASED, 64'd0},
    '{ROW_REQ, TOP,        16'hFFFF, 1'b1, KIND_BEYOND,   TOP},
    '{ROW_REQ, 64'd31,     16'h3C3C, 1'b0, KIND_PARKED,   64'd0},
    '{ROW_REQ, 64'd0,      16'h0002, 1'b1, KIND_RELEASED, 64'd0},
    '{ROW_CFG, 64'd0,      16'h0000, 1'b0, KIND_RELEASED, 64'd0},
    '{ROW_REQ, 64'd0,      16'h0004, 1'b1, KIND_RELEASED, 64'd0},
    '{ROW_CFG, TOP,        16'h0000, 1'b0, KIND_RELEASED, 64'd0},
    '{ROW_REQ, TOP,        16'hFFFF, 1'b1, KIND_RELEASED, TOP},
    '{ROW_CFG, 64'd1,      16'h0000, 1'b0, KIND_RELEASED, 64'd0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [63:0]            in_sequence;
  logic [HANDLE_BITS-1:0] in_handle;
  logic                   cfg_we;
  logic [63:0]            cfg_data;
  logic                   out_valid;
  logic [1:0]             out_result_kind;
  logic [63:0]            out_sequence;
  logic [HANDLE_BITS-1:0] out_handle;
  logic [63:0]            out_applied_count;
  logic                   out_last_of_run;

  // fixed result for a directed request, used in place of the prediction
  logic                   typed_ok;
  kind_t                  typed_kind;
  logic [63:0]            typed_applied;

  // predicted window state
  logic [WINDOW-1:0]      slot_wait;
  logic [HANDLE_BITS-1:0] slot_hdl [WINDOW];
  logic [63:0]            exp_next;

  result_t                pending [$];
  result_t                held;
  logic                   held_ok;
  int                     run_count;
  int                     errors;
  int                     quiet;
  int                     burst_left;

  in_order_release_reorder_buffer #(
    .WINDOW      (WINDOW),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_sequence       (in_sequence),
    .in_handle         (in_handle),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_result_kind   (out_result_kind),
    .out_sequence      (out_sequence),
    .out_handle        (out_handle),
    .out_applied_count (out_applied_count),
    .out_last_of_run   (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic note_result(input kind_t kind, input logic [63:0] seq,
                             input logic [HANDLE_BITS-1:0] hdl);
    if (held_ok) begin
      pending.push_back(held);
    end
    held = '{kind, seq, hdl, exp_next - 64'd1, 1'b0};
    held_ok = 1'b1;
    run_count++;
  endtask

  task automatic predict_request(input logic [63:0] seq, input logic [HANDLE_BITS-1:0] hdl);
    logic [SLOT_W-1:0] slot;
    logic [63:0]       rel;
    run_count = 0;
    held_ok = 1'b0;
    if (seq < exp_next) begin
      note_result(KIND_STALE, seq, hdl);
    end else if (seq - exp_next >= 64'(WINDOW)) begin
      note_result(KIND_BEYOND, seq, hdl);
    end else begin
      slot = seq[SLOT_W-1:0];
      slot_wait[slot] = 1'b1;
      slot_hdl[slot] = hdl;
      if (seq != exp_next) begin
        note_result(KIND_PARKED, seq, hdl);
      end
    end
    while (run_count < MAX_OUT && slot_wait[exp_next[SLOT_W-1:0]]) begin
      slot = exp_next[SLOT_W-1:0];
      slot_wait[slot] = 1'b0;
      rel = exp_next;
      exp_next = exp_next + 64'd1;
      note_result(KIND_RELEASED, rel, slot_hdl[slot]);
    end
    if (held_ok) begin
      held.last = 1'b1;
      pending.push_back(held);
      held_ok = 1'b0;
    end
  endtask

  // checks results, tracks the window state, and runs the watchdog
  always @(posedge clk) begin
    result_t want;
    int      n0;
    if (!rst_n) begin
      exp_next = 64'd1;
      slot_wait = '0;
      quiet = 0;
    end else begin
      if (out_valid) begin
        if (pending.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result: kind %0d seq %h handle %h applied %h last %0b",
                     out_result_kind, out_sequence, out_handle, out_applied_count,
                     out_last_of_run);
          end
        end else begin
          want = pending.pop_front();
          if (out_result_kind !== want.kind || out_sequence !== want.seq ||
              out_handle !== want.hdl || out_applied_count !== want.applied ||
              out_last_of_run !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch expected: kind %0d seq %h handle %h applied %h last %0b",
                       want.kind, want.seq, want.hdl, want.applied, want.last);
              $display("         actual:   kind %0d seq %h handle %h applied %h last %0b",
                       out_result_kind, out_sequence, out_handle, out_applied_count,
                       out_last_of_run);
            end
          end
        end
      end
      if (cfg_we) begin
        exp_next = cfg_data;
        slot_wait = '0;
      end
      if (start && !busy) begin
        n0 = pending.size();
        predict_request(in_sequence, in_handle);
        if (typed_ok) begin
          while (pending.size() > n0) begin
            void'(pending.pop_back());
          end
          want = '{typed_kind, in_sequence, in_handle, typed_applied, 1'b1};
          pending.push_back(want);
        end
      end
      if ((start && !busy) || out_valid) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_req(input logic [63:0] seq, input logic [HANDLE_BITS-1:0] hdl,
                          input logic typed, input kind_t kind,
                          input logic [63:0] applied);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    start = 1'b1;
    in_sequence = seq;
    in_handle = hdl;
    typed_ok = typed;
    typed_kind = kind;
    typed_applied = applied;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic write_first_sequence(input logic [63:0] value);
    start = 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    logic [63:0] run_seq [WINDOW];
    logic [63:0] base;
    logic [63:0] tmp;
    int          i;
    int          j;
    int          k;
    int          len;
    int          sent;
    int          run_no;
    rst_n = 1'b0;
    start = 1'b0;
    in_sequence = '0;
    in_handle = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    typed_ok = 1'b0;
    typed_kind = KIND_RELEASED;
    typed_applied = '0;
    held_ok = 1'b0;
    errors = 0;
    burst_left = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].op == ROW_CFG) begin
        write_first_sequence(DIRECTED[i].seq);
      end else begin
        send_req(DIRECTED[i].seq, DIRECTED[i].hdl, DIRECTED[i].typed,
                 DIRECTED[i].kind, DIRECTED[i].applied);
      end
    end

    // runs of consecutive sequences sent shuffled, with noise and resends mixed in
    sent = 0;
    run_no = 0;
    while (sent < RANDOM_ITEMS) begin
      if (run_no % 6 == 5) begin
        case ($urandom_range(0, 2))
          0: tmp = {$urandom, $urandom};
          1: tmp = 64'($urandom_range(0, 100));
          default: tmp = TOP - 64'($urandom_range(0, 40));
        endcase
        write_first_sequence(tmp);
      end
      if (run_no == 0 || $urandom_range(0, 19) == 0) begin
        len = WINDOW;
      end else begin
        len = $urandom_range(1, 8);
      end
      base = exp_next;
      for (k = 0; k < len; k++) begin
        run_seq[k] = base + 64'(k);
      end
      for (k = len - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        tmp = run_seq[k];
        run_seq[k] = run_seq[j];
        run_seq[j] = tmp;
      end
      // first run holds back the head so that one request releases the full window
      if (run_no == 0) begin
        for (k = 0; k < len; k++) begin
          if (run_seq[k] == base) begin
            run_seq[k] = run_seq[len - 1];
            run_seq[len - 1] = base;
          end
        end
      end
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 6) == 0) begin
          case ($urandom_range(0, 2))
            0: tmp = (exp_next == 64'd0) ? {$urandom, $urandom}
                                         : {$urandom, $urandom} % exp_next;
            1: tmp = exp_next + 64'(WINDOW) +
                     (($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 63))
                                                  : {$urandom, $urandom});
            default: tmp = exp_next + 64'($urandom_range(1, WINDOW - 1));
          endcase
          send_req(tmp, HANDLE_BITS'($urandom), 1'b0, KIND_RELEASED, '0);
          sent++;
        end
        send_req(run_seq[k], HANDLE_BITS'($urandom), 1'b0, KIND_RELEASED, '0);
        sent++;
        if ($urandom_range(0, 15) == 0) begin
          send_req(run_seq[k], HANDLE_BITS'($urandom), 1'b0, KIND_RELEASED, '0);
          sent++;
        end
      end
      run_no++;
    end

    start = 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
